>>> sv/tzc_pkg.sv
// Shared types and constants for the touch zone classifier.
// Depends on nothing; every other file imports it.
package tzc_pkg;

  localparam int ZONES_DEFAULT = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;

  localparam logic [7:0] CODE_MODE = 8'hFE;
  localparam logic [7:0] CODE_SHOT = 8'hFD;

  localparam logic REG_ENABLE     = 1'b0;
  localparam logic REG_ZONE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_CODE
  } state_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        wid;
    logic [14:0]        hgt;
    logic [7:0]         code;
  } zone_entry_t;

  typedef struct packed {
    logic enable;
    logic drop;
  } cfg_ctl_t;

endpackage

>>> sv/tzc_zone_store.sv
// Zone table: one write port and one registered read port.
// Depends on tzc_pkg for the entry layout.
module tzc_zone_store #(
  parameter int ZONES = tzc_pkg::ZONES_DEFAULT,
  parameter int IDX_W = (ZONES > 1) ? $clog2(ZONES) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  tzc_pkg::zone_entry_t wr_entry,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output tzc_pkg::zone_entry_t rd_entry
);
  import tzc_pkg::*;

  zone_entry_t mem [ZONES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

>>> sv/tzc_contain.sv
// Containment test of one point against one zone rectangle.
// Depends on tzc_pkg for the entry layout.
module tzc_contain (
  input  logic signed [15:0]   x,
  input  logic signed [15:0]   y,
  input  tzc_pkg::zone_entry_t entry,
  output logic                 hit
);
  import tzc_pkg::*;

  logic signed [16:0] x_ext;
  logic signed [16:0] y_ext;
  logic signed [16:0] left_ext;
  logic signed [16:0] top_ext;
  logic signed [16:0] right_ext;
  logic signed [16:0] bottom_ext;

  assign x_ext      = {x[15], x};
  assign y_ext      = {y[15], y};
  assign left_ext   = {entry.left[15], entry.left};
  assign top_ext    = {entry.top[15], entry.top};
  assign right_ext  = left_ext + $signed({2'b00, entry.wid});
  assign bottom_ext = top_ext + $signed({2'b00, entry.hgt});

  assign hit = (x_ext >= left_ext) && (x_ext < right_ext) &&
               (y_ext >= top_ext) && (y_ext < bottom_ext);

endmodule

>>> sv/tzc_ctrl.sv
// Sequencer: scans the zone table one entry a cycle, keeps held and edge
// state, and builds the frame result. Depends on tzc_pkg and tzc_contain.
module tzc_ctrl #(
  parameter int ZONES = tzc_pkg::ZONES_DEFAULT,
  parameter int IDX_W = (ZONES > 1) ? $clog2(ZONES) : 1,
  parameter int CNT_W = $clog2(ZONES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [3:0]           zone_index,
  input  logic signed [15:0]   pos_x,
  input  logic signed [15:0]   pos_y,
  input  logic [14:0]          zone_width,
  input  logic [14:0]          zone_height,
  input  logic [7:0]           zone_code,
  input  logic                 last_point,
  input  tzc_pkg::cfg_ctl_t    cfg,
  input  logic [CNT_W-1:0]     n_act,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output tzc_pkg::zone_entry_t wr_entry,
  output logic                 rd_en,
  output logic [IDX_W-1:0]     rd_addr,
  input  tzc_pkg::zone_entry_t rd_entry,
  output logic                 done,
  output logic                 consumed,
  output logic [ZONES-1:0]     held,
  output logic [7:0]           first_code,
  output logic                 mode_ev,
  output logic                 shot_ev
);
  import tzc_pkg::*;

  state_t state;
  state_t state_next;

  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  logic               last_q;
  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   cnt;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic [ZONES-1:0]   frame_acc;
  logic [ZONES-1:0]   held_set;
  logic               fm_seen;
  logic               fs_seen;
  logic               mode_down;
  logic               shot_down;
  logic [IDX_W-1:0]   first_idx;
  logic               first_any;

  logic accept;
  logic active;
  logic issue;
  logic contain_hit;
  logic hit;
  logic scan_end;
  logic code_ok;
  logic drop;
  logic quick_result;

  tzc_contain u_contain (
    .x     (x_q),
    .y     (y_q),
    .entry (rd_entry),
    .hit   (contain_hit)
  );

  assign accept   = start && (state == ST_IDLE);
  assign active   = cfg.enable && (n_act != '0);
  assign issue    = (state == ST_SCAN) && (cnt < n_q);
  assign hit      = (state == ST_SCAN) && pend && contain_hit;
  assign scan_end = hit || (!issue && !pend);
  assign code_ok  = first_any && (CNT_W'(first_idx) < n_q);

  assign drop = cfg.drop ||
                (accept && ((opcode == OP_LOAD) || (opcode == OP_EMPTY) ||
                            ((opcode == OP_POINT) && !active)));
  assign quick_result = accept &&
                        ((opcode == OP_EMPTY) ||
                         ((opcode == OP_POINT) && !active && last_point));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_POINT) && active) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (last_q && code_ok) begin
          state_next = ST_CODE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CODE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // memory and handshake controls
  always_comb begin
    busy    = 1'b1;
    rd_en   = 1'b0;
    rd_addr = cnt[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        rd_en = issue;
      end
      ST_FINISH: begin
        rd_en   = last_q && code_ok;
        rd_addr = first_idx;
      end
      ST_CODE: begin
        rd_en = 1'b0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign wr_en         = accept && (opcode == OP_LOAD) && (32'(zone_index) < ZONES);
  assign wr_addr       = IDX_W'(zone_index);
  assign wr_entry.left = pos_x;
  assign wr_entry.top  = pos_y;
  assign wr_entry.wid  = zone_width;
  assign wr_entry.hgt  = zone_height;
  assign wr_entry.code = zone_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the point under test
  always_ff @(posedge clk) begin
    if (accept) begin
      x_q    <= pos_x;
      y_q    <= pos_y;
      last_q <= last_point;
      n_q    <= n_act;
    end
  end

  // advance the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      pend     <= 1'b0;
      pend_idx <= '0;
    end else if (accept) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (state == ST_SCAN) begin
      pend     <= issue && !hit;
      pend_idx <= cnt[IDX_W-1:0];
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // held set, frame accumulators and edge flags
  always_ff @(posedge clk) begin
    if (rst || drop) begin
      frame_acc <= '0;
      held_set  <= '0;
      fm_seen   <= 1'b0;
      fs_seen   <= 1'b0;
      mode_down <= 1'b0;
      shot_down <= 1'b0;
      first_idx <= '0;
      first_any <= 1'b0;
    end else if (hit) begin
      if (rd_entry.code == CODE_MODE) begin
        fm_seen <= 1'b1;
      end else if (rd_entry.code == CODE_SHOT) begin
        fs_seen <= 1'b1;
      end else begin
        frame_acc <= frame_acc | (ZONES'(1) << pend_idx);
        if (!first_any || (pend_idx < first_idx)) begin
          first_idx <= pend_idx;
          first_any <= 1'b1;
        end
      end
    end else if ((state == ST_FINISH) && last_q) begin
      held_set  <= frame_acc;
      mode_down <= fm_seen;
      shot_down <= fs_seen;
      frame_acc <= '0;
      fm_seen   <= 1'b0;
      fs_seen   <= 1'b0;
      first_idx <= '0;
      first_any <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= quick_result ||
              ((state == ST_FINISH) && last_q && !code_ok) ||
              (state == ST_CODE);
    end
  end

  always_ff @(posedge clk) begin
    if (quick_result) begin
      consumed   <= active;
      held       <= '0;
      first_code <= '0;
      mode_ev    <= 1'b0;
      shot_ev    <= 1'b0;
    end else if ((state == ST_FINISH) && last_q) begin
      consumed   <= 1'b1;
      held       <= frame_acc;
      first_code <= '0;
      mode_ev    <= fm_seen && !mode_down;
      shot_ev    <= fs_seen && !shot_down;
    end else if (state == ST_CODE) begin
      first_code <= rd_entry.code;
    end
  end

endmodule

>>> sv/touch_zone_classifier.sv
// Top level of the touch zone classifier: configuration registers, zone
// table and sequencer. Depends on tzc_pkg, tzc_zone_store and tzc_ctrl.
//
//  channel   ports                                           handshake
//  request   opcode zone_index pos_x pos_y zone_width        start & !busy
//            zone_height zone_code last_point
//  result    consumed held_mask first_held_code              done, one cycle
//            mode_event shot_event
//  config    wr_index wr_data                                wr_en
//
// A touch point with the block active holds busy: one entry is read per cycle, up
// to zone_count (capped at ZONES), and tested in the following cycle by the
// single containment unit; the scan stops at the first hit. A finish step closes
// the frame on the last point; one more step fetches the first held code if any.
// On the last point done follows in the first cycle with busy low. Other requests
// never raise busy. Reset is synchronous; the table holds nothing defined until
// loaded. done is a one-cycle strobe; the receiver cannot stall.
module touch_zone_classifier #(
  parameter int ZONES = tzc_pkg::ZONES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [3:0]         zone_index,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [14:0]        zone_width,
  input  logic [14:0]        zone_height,
  input  logic [7:0]         zone_code,
  input  logic               last_point,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [4:0]         wr_data,
  output logic               done,
  output logic               consumed,
  output logic [15:0]        held_mask,
  output logic [7:0]         first_held_code,
  output logic               mode_event,
  output logic               shot_event
);
  import tzc_pkg::*;

  localparam int IDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int CNT_W = $clog2(ZONES + 1);

  logic              enable;
  logic [4:0]        zone_count;
  logic [CNT_W-1:0]  n_act;
  cfg_ctl_t          cfg;

  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  zone_entry_t       mem_wr_entry;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  zone_entry_t       mem_rd_entry;

  logic [ZONES-1:0]  held;
  logic [ZONES+15:0] held_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      zone_count <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENABLE:     enable     <= wr_data[0];
        REG_ZONE_COUNT: zone_count <= wr_data;
        default:        enable     <= enable;
      endcase
    end
  end

  assign n_act      = (32'(zone_count) > ZONES) ? CNT_W'(ZONES) : CNT_W'(zone_count);
  assign cfg.enable = enable;
  assign cfg.drop   = wr_en && (wr_index == REG_ENABLE) && !wr_data[0];

  tzc_zone_store #(
    .ZONES (ZONES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_entry (mem_wr_entry),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_entry (mem_rd_entry)
  );

  tzc_ctrl #(
    .ZONES (ZONES),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .zone_index  (zone_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .zone_width  (zone_width),
    .zone_height (zone_height),
    .zone_code   (zone_code),
    .last_point  (last_point),
    .cfg         (cfg),
    .n_act       (n_act),
    .wr_en       (mem_wr_en),
    .wr_addr     (mem_wr_addr),
    .wr_entry    (mem_wr_entry),
    .rd_en       (mem_rd_en),
    .rd_addr     (mem_rd_addr),
    .rd_entry    (mem_rd_entry),
    .done        (done),
    .consumed    (consumed),
    .held        (held),
    .first_code  (first_held_code),
    .mode_ev     (mode_event),
    .shot_ev     (shot_event)
  );

  assign held_wide = {16'b0, held};
  assign held_mask = held_wide[15:0];

endmodule
